/* rtl/core/fbwa_pkg.sv */
`default_nettype none
package fbwa_pkg;

   // Table geometry.
   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
   localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

   // Field widths fixed by the interface.
   localparam int REQ_NUM_BITS = 8;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DAT_BITS = 5;

   // Command codes.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   // Placement policy codes; the unused code behaves as first fit.
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIT_POLICY    = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCKS_IN_USE = 1'd1;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  block_index;
      logic [15:0] size_value;
      logic        last_request;
   } req_word_type;

   typedef struct packed {
      logic        granted;
      logic [3:0]  chosen_block;
      logic [15:0] remaining_size;
      logic [7:0]  request_number;
      logic        batch_end;
   } rsp_word_type;

   // Verdict of the shared compare unit on one candidate block.
   typedef struct packed {
      logic fits;
      logic take;
      logic stop;
   } cmp_result_type;

endpackage
`default_nettype wire

/* rtl/core/fbwa_fit_cmp.sv */
`default_nettype none
module fbwa_fit_cmp (
   input  wire logic [1:0]                    policy,
   input  wire logic [fbwa_pkg::SIZE_BITS-1:0] cand_size,
   input  wire logic [fbwa_pkg::SIZE_BITS-1:0] req_size,
   input  wire logic                          best_found,
   input  wire logic [fbwa_pkg::SIZE_BITS-1:0] best_size,
   output fbwa_pkg::cmp_result_type           verdict
);

   logic fits;
   logic better;
   logic ranked;

   // A candidate fits when it can hold the whole request.
   assign fits = (cand_size >= req_size);

   // Best and worst fit replace the held block only on a strict improvement,
   // so ties stay with the lower index.
   always_comb begin
      ranked = 1'b0;
      better = 1'b0;
      case (policy)
         fbwa_pkg::FIT_BEST: begin
            ranked = 1'b1;
            better = (cand_size < best_size);
         end
         fbwa_pkg::FIT_WORST: begin
            ranked = 1'b1;
            better = (cand_size > best_size);
         end
         default: begin
            ranked = 1'b0;
            better = 1'b0;
         end
      endcase
   end

   assign verdict.fits = fits;
   assign verdict.take = fits && (!best_found || better);
   // First fit ends the scan at the first block that fits.
   assign verdict.stop = fits && !ranked;

endmodule
`default_nettype wire

/* rtl/core/fit_policy_block_allocator_core.sv */
`default_nettype none
// Fit-policy block allocator. A load word (cmd 0) writes one block's free
// size and produces no response. An allocate word (cmd 1) scans blocks 0 to
// blocks_in_use-1, clamped to the table depth, with one shared comparator,
// one block per cycle, then, once the response register is free, writes the
// reduced size back and loads the response register. Under first fit the
// scan ends early at the first block that fits. req_stall stays high until
// the response is loaded, and the next word is taken while that response
// still waits on rsp_stall. Reset clears the size table, the request counter
// and the registers at once (fit_policy first fit, blocks_in_use 16); the
// user must see that configuration is written only while no allocate is in
// flight, as the block itself does not enforce this.
module fit_policy_block_allocator_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire fbwa_pkg::req_word_type                req_word,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      fbwa_pkg::rsp_word_type                rsp_word,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [fbwa_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [fbwa_pkg::CSR_DAT_BITS-1:0]     csr_wdata
);

   localparam int SB = fbwa_pkg::SIZE_BITS;
   localparam int IB = fbwa_pkg::IDX_BITS;
   localparam int CB = fbwa_pkg::CNT_BITS;
   localparam int NB = fbwa_pkg::REQ_NUM_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   state_type               state_ff, state_in;
   logic [CB-1:0]           scan_ff, scan_in;
   logic [SB-1:0]           req_size_ff, req_size_in;
   logic                    last_ff, last_in;
   logic                    found_ff, found_in;
   logic [IB-1:0]           best_idx_ff, best_idx_in;
   logic [SB-1:0]           best_size_ff, best_size_in;
   logic [NB-1:0]           req_count_ff, req_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   fbwa_pkg::rsp_word_type  rsp_word_ff, rsp_word_in;
   logic [1:0]              policy_ff;
   logic [CB-1:0]           blocks_ff;

   // Size table with one valid bit per entry; an unwritten entry reads zero.
   logic [SB-1:0]           table_ff [fbwa_pkg::NUM_BLOCKS];
   logic [fbwa_pkg::NUM_BLOCKS-1:0] tvalid_ff;
   logic                    tbl_we;
   logic [IB-1:0]           tbl_waddr;
   logic [SB-1:0]           tbl_wdata;
   logic [SB-1:0]           cand_size;

   logic                    req_fire;
   logic                    rsp_free;
   logic [CB-1:0]           limit;
   logic [CB-1:0]           scan_next;
   logic [SB-1:0]           remaining;
   fbwa_pkg::cmp_result_type verdict;

   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_next = CB'(scan_ff + 1'b1);
   assign remaining = best_size_ff - req_size_ff;

   // Blocks examined per request, clamped to the table depth.
   assign limit = (blocks_ff > CB'(fbwa_pkg::NUM_BLOCKS)) ?
                  CB'(fbwa_pkg::NUM_BLOCKS) : blocks_ff;

   // Candidate read at the scan pointer.
   assign cand_size = tvalid_ff[scan_ff[IB-1:0]] ? table_ff[scan_ff[IB-1:0]] : '0;

   fbwa_fit_cmp u_cmp (
      .policy     (policy_ff),
      .cand_size  (cand_size),
      .req_size   (req_size_ff),
      .best_found (found_ff),
      .best_size  (best_size_ff),
      .verdict    (verdict)
   );

   // Table writes: a load word in idle, or the write-back of a granted block.
   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = best_idx_ff;
      tbl_wdata = remaining;
      if (state_ff == ST_IDLE && req_fire && req_word.cmd == fbwa_pkg::CMD_LOAD) begin
         tbl_we    = 1'b1;
         tbl_waddr = IB'(req_word.block_index);
         tbl_wdata = SB'(req_word.size_value);
      end else if (state_ff == ST_WRITE && rsp_free && found_ff) begin
         tbl_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff <= '0;
      end else if (tbl_we) begin
         tvalid_ff[tbl_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_ff[tbl_waddr] <= tbl_wdata;
      end
   end

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= fbwa_pkg::FIT_FIRST;
         blocks_ff <= CB'(fbwa_pkg::NUM_BLOCKS);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fbwa_pkg::CSR_FIT_POLICY:    policy_ff <= csr_wdata[1:0];
            fbwa_pkg::CSR_BLOCKS_IN_USE: blocks_ff <= CB'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Sequencer: accept, scan one block per cycle, then write back and respond.
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      req_size_in  = req_size_ff;
      last_in      = last_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_size_in = best_size_ff;
      req_count_in = req_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_word.cmd == fbwa_pkg::CMD_LOAD) begin
                  req_count_in = '0;
               end else begin
                  scan_in     = '0;
                  found_in    = 1'b0;
                  req_size_in = SB'(req_word.size_value);
                  last_in     = req_word.last_request;
                  state_in    = (limit == '0) ? ST_WRITE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (verdict.take) begin
               found_in     = 1'b1;
               best_idx_in  = scan_ff[IB-1:0];
               best_size_in = cand_size;
            end
            scan_in = scan_next;
            if (verdict.stop || scan_next == limit) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.granted         = found_ff;
               rsp_word_in.chosen_block    = found_ff ? 4'(best_idx_ff) : '0;
               rsp_word_in.remaining_size  = found_ff ? 16'(remaining) : '0;
               rsp_word_in.request_number  = 8'(req_count_ff);
               rsp_word_in.batch_end       = last_ff;
               req_count_in = last_ff ? '0 : NB'(req_count_ff + 1'b1);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         found_ff     <= 1'b0;
         req_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         req_count_ff <= req_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff      <= scan_in;
      req_size_ff  <= req_size_in;
      last_ff      <= last_in;
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // A new response word appears only out of the write-back step.
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_WRITE)
      else $error("response raised outside write-back");

   // The held candidate always holds the request.
   a_best_fits: assert property (@(posedge clock) disable iff (reset)
      (found_ff && state_ff != ST_IDLE) |-> best_size_ff >= req_size_ff)
      else $error("held block smaller than request");

   // An accepted allocate word starts the sequencer.
   a_alloc_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_word.cmd == fbwa_pkg::CMD_ALLOC) |=> state_ff != ST_IDLE)
      else $error("allocate word did not start a scan");

   // A failed request reports a zero block and size.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.granted) |->
         (rsp_word_ff.chosen_block == '0 && rsp_word_ff.remaining_size == '0))
      else $error("failed request carries nonzero fields");

endmodule
`default_nettype wire
